// ===== hw/rtl/grbf_pkg.sv =====
// Shared types, constants and the exp(-x) table for the RBF network evaluator.
`timescale 1ns / 1ps

package grbf_pkg;

   localparam int MAX_KERNELS = 64;
   localparam int NUM_OUTPUTS = 4;
   localparam int EXP_DEPTH   = 256;   // power of two
   localparam int OUT_FIELDS  = 4;

   localparam int KIDX_W    = $clog2(MAX_KERNELS);
   localparam int CNT_W     = $clog2(MAX_KERNELS + 1);
   localparam int EXP_IDX_W = $clog2(EXP_DEPTH);
   localparam int ACT_W     = 17;                  // Q1.16, max 1.0
   localparam int PROD_W    = 16 + ACT_W;
   localparam int ACC_W     = PROD_W + $clog2(MAX_KERNELS) + 1;
   localparam int D2_W      = 34;                  // unsigned Q6.28
   localparam int P_W       = D2_W + 16;           // unsigned Q14.36
   localparam int P_FRAC    = 40;                  // 1.0 of table argument / 16
   localparam int PIPE_STAGES = 6;

   typedef enum logic [1:0] {
      OP_WRITE_CENTER = 2'd0,
      OP_WRITE_WEIGHT = 2'd1,
      OP_EVALUATE     = 2'd2,
      OP_RESERVED     = 2'd3
   } op_type;

   localparam logic [7:0] CSR_ACTIVE_KERNELS = 8'd0;
   localparam logic [7:0] CSR_INV_SIGMA      = 8'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } grbf_state_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [5:0]         kernel_index;
      logic [1:0]         output_select;
      logic signed [15:0] value_a;
      logic signed [15:0] value_b;
   } grbf_req_type;

   typedef struct packed {
      logic signed [15:0] angle_0;
      logic signed [15:0] angle_1;
      logic signed [15:0] angle_2;
      logic signed [15:0] angle_3;
   } grbf_rsp_type;

   typedef struct packed {
      logic              wr_center;
      logic              wr_weight;
      logic              start;
      logic              issue;
      logic [KIDX_W-1:0] kaddr;
      logic              load_out;
   } grbf_cmd_type;

   typedef struct packed {
      logic pipe_busy;
   } grbf_status_type;

   typedef logic [ACT_W-1:0] exp_rom_type [EXP_DEPTH];

   // exp(-16*i/depth) in Q1.16: truncated series on a sixteenth of the
   // argument, then squared four times, all in Q30.
   function automatic exp_rom_type build_exp_rom();
      exp_rom_type rom;
      logic [63:0] f;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] one;
      for (int i = 0; i < EXP_DEPTH; i++) begin
         one  = 64'd1 << 30;
         f    = (64'(i) << 30) / EXP_DEPTH;
         term = one;
         sum  = one;
         for (int k = 1; k <= 14; k++) begin
            term = ((term * f) >> 30) / 64'(k);
            if (k % 2 == 1) begin
               sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         if (sum > one) begin
            sum = one;
         end
         for (int n = 0; n < 4; n++) begin
            sum = (sum * sum + (one >> 1)) >> 30;
         end
         sum = (sum + (64'd1 << 13)) >> 14;
         rom[i] = (sum > 64'd65536) ? ACT_W'(65536) : ACT_W'(sum);
      end
      return rom;
   endfunction

   localparam exp_rom_type EXP_ROM = build_exp_rom();

endpackage

// ===== hw/rtl/grbf_ctrl.sv =====
// Sequencer: request decode, kernel sweep, pipeline drain and result handoff.
`timescale 1ns / 1ps

module grbf_ctrl import grbf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [1:0]      req_operation,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  logic [6:0]      active_kernels,
   input  grbf_status_type status,
   output grbf_cmd_type    cmd
);

   grbf_state_type  state_ff, state_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] count;
   logic             rsp_valid_ff, rsp_valid_in;

   // more active kernels than stored ones saturate
   assign count = (32'(active_kernels) > MAX_KERNELS) ? CNT_W'(MAX_KERNELS)
                                                      : CNT_W'(active_kernels);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.kaddr    = k_ff[KIDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_operation)
                  OP_WRITE_CENTER: cmd.wr_center = 1'b1;
                  OP_WRITE_WEIGHT: cmd.wr_weight = 1'b1;
                  OP_EVALUATE: begin
                     cmd.start = 1'b1;
                     k_in      = '0;
                     state_in  = (count == '0) ? ST_DRAIN : ST_RUN;
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            k_in      = k_ff + CNT_W'(1);
            if (k_in == count) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/grbf_datapath.sv =====
// Kernel tables, distance/exp pipeline, per-output MACs and result register.
`timescale 1ns / 1ps

module grbf_datapath import grbf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  grbf_cmd_type    cmd,
   output grbf_status_type status,
   input  grbf_req_type    req_data,
   input  logic [15:0]     inv_sigma,
   output grbf_rsp_type    rsp_data
);

   localparam int W_DLY = PIPE_STAGES - 1;

   logic [31:0]            center_mem [MAX_KERNELS];
   logic [31:0]            cen_rd_ff;
   logic signed [15:0]     x_ff, y_ff;
   logic signed [16:0]     dx, dy;
   logic [32:0]            sqx_ff, sqy_ff;
   logic [D2_W-1:0]        d2_ff;
   logic [P_W-1:0]         p_ff;
   logic [EXP_IDX_W-1:0]   exp_idx;
   logic                   exp_ovf;
   logic [ACT_W-1:0]       act_ff;
   logic [PIPE_STAGES-1:0] vld_ff;
   logic signed [15:0]     result [OUT_FIELDS];
   grbf_rsp_type           rsp_data_ff;
   logic                   kidx_ok;

   function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W:0]    r;
      logic signed [ACC_W-16:0] q;
      r = $signed({a[ACC_W-1], a}) + (ACC_W+1)'(32768);
      q = r[ACC_W:16];
      if (q > (ACC_W-15)'(32767)) begin
         return 16'sh7fff;
      end else if (q < (ACC_W-15)'(-32768)) begin
         return 16'sh8000;
      end
      return q[15:0];
   endfunction

   assign kidx_ok = 32'(req_data.kernel_index) < MAX_KERNELS;

   always_ff @(posedge clock) begin
      if (cmd.wr_center && kidx_ok) begin
         center_mem[KIDX_W'(req_data.kernel_index)] <= {req_data.value_a, req_data.value_b};
      end
      if (cmd.issue) begin
         cen_rd_ff <= center_mem[cmd.kaddr];
      end
   end

   assign dx = 17'(x_ff) - 17'($signed(cen_rd_ff[31:16]));
   assign dy = 17'(y_ff) - 17'($signed(cen_rd_ff[15:0]));

   // table index = floor(P * depth / 2^40)
   assign exp_idx = p_ff[P_FRAC-EXP_IDX_W +: EXP_IDX_W];
   assign exp_ovf = |p_ff[P_W-1:P_FRAC];

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff <= req_data.value_a;
         y_ff <= req_data.value_b;
      end
      sqx_ff <= 33'(dx * dx);
      sqy_ff <= 33'(dy * dy);
      d2_ff  <= D2_W'(sqx_ff) + D2_W'(sqy_ff);
      p_ff   <= P_W'(d2_ff) * P_W'(inv_sigma);
      act_ff <= exp_ovf ? '0 : EXP_ROM[exp_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_STAGES-2:0], cmd.issue};
      end
   end

   assign status.pipe_busy = |vld_ff;

   for (genvar j = 0; j < OUT_FIELDS; j++) begin : g_out
      if (j < NUM_OUTPUTS) begin : g_bank
         logic [15:0]               wmem [MAX_KERNELS];
         logic signed [15:0]        w_dly_ff [W_DLY];
         logic signed [PROD_W-1:0]  prod_ff;
         logic signed [ACC_W-1:0]   acc_ff;

         always_ff @(posedge clock) begin
            if (cmd.wr_weight && kidx_ok && (32'(req_data.output_select) == j)) begin
               wmem[KIDX_W'(req_data.kernel_index)] <= req_data.value_a;
            end
            if (cmd.issue) begin
               w_dly_ff[0] <= $signed(wmem[cmd.kaddr]);
            end
            for (int s = 1; s < W_DLY; s++) begin
               w_dly_ff[s] <= w_dly_ff[s-1];
            end
            prod_ff <= PROD_W'(w_dly_ff[W_DLY-1] * $signed({1'b0, act_ff}));
            if (cmd.start) begin
               acc_ff <= '0;
            end else if (vld_ff[PIPE_STAGES-1]) begin
               acc_ff <= acc_ff + ACC_W'(prod_ff);
            end
         end

         assign result[j] = round_sat(acc_ff);
      end else begin : g_unused
         assign result[j] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff.angle_0 <= result[0];
         rsp_data_ff.angle_1 <= result[1];
         rsp_data_ff.angle_2 <= result[2];
         rsp_data_ff.angle_3 <= result[3];
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

// ===== hw/rtl/gaussian_rbf_network_eval.sv =====
// Top level of the two-input Gaussian RBF network evaluator.
// Loads (center or weight write) and reserved requests are taken back to back.
// Evaluate: N = min(active_kernels, 64) kernels, one per cycle through a shared
// distance/exp pipeline with four MACs; the next request can be taken in the same cycle
// that the result goes valid; a stalled result holds only the next evaluate's handoff.
// Sync reset: active_kernels = 64, inv_sigma = 1.0.
`timescale 1ns / 1ps

module gaussian_rbf_network_eval import grbf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  grbf_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output grbf_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   logic [6:0]      active_kernels_ff;
   logic [15:0]     inv_sigma_ff;
   grbf_cmd_type    cmd;
   grbf_status_type status;

   // Register file: always ready, unknown indexes are dropped.
   // Kernel tables are not cleared at reset and must be written before use.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_kernels_ff <= 7'd64;
         inv_sigma_ff      <= 16'd256;
      end else if (csr_valid) begin
         if (csr_index == CSR_ACTIVE_KERNELS) begin
            active_kernels_ff <= csr_wdata[6:0];
         end
         if (csr_index == CSR_INV_SIGMA) begin
            inv_sigma_ff <= csr_wdata;
         end
      end
   end

   // Sequencer: decodes each request and walks the kernel index.
   grbf_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_data.operation),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .active_kernels (active_kernels_ff),
      .status         (status),
      .cmd            (cmd)
   );

   // Datapath: tables, squared distance, scale, exp lookup, MAC, round/saturate.
   grbf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .inv_sigma (inv_sigma_ff),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/grbf_checker.sv =====
// Port-level checks for the RBF network evaluator, bound to the top level.
`timescale 1ns / 1ps

module grbf_checker import grbf_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input grbf_req_type req_data,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input grbf_rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.operation == OP_EVALUATE) |=> !req_ready)
      else $error("new request taken while an evaluate runs");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without an evaluate in progress");

endmodule

bind gaussian_rbf_network_eval grbf_checker u_grbf_checker (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for the Gaussian RBF network evaluator.
`timescale 1ns / 1ps

module testbench;
   import grbf_pkg::*;

   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 80;    // one full 64-kernel evaluate plus margin
   localparam int IDLE_LIMIT    = 2000;  // cycles with no handshake before giving up
   localparam logic [7:0] CSR_UNMAPPED_LO = 8'd2;
   localparam logic [7:0] CSR_UNMAPPED_HI = 8'hFF;
   localparam logic [63:0] Q30_ONE = 64'd1 << 30;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   grbf_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   grbf_rsp_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_index = '0;
   logic [15:0]  csr_wdata = '0;

   gaussian_rbf_network_eval dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // One queued action: either a request or a register write.
   typedef struct {
      logic         is_csr;
      grbf_req_type req;
      logic [7:0]   reg_index;
      logic [15:0]  wdata;
   } backlog_type;

   backlog_type  op_backlog [$];
   grbf_rsp_type angle_queue [$];

   // Predictor state: tables, registers and the exp(-x) lookup.
   logic signed [15:0] center_x [MAX_KERNELS];
   logic signed [15:0] center_y [MAX_KERNELS];
   logic signed [15:0] weight_mem [NUM_OUTPUTS][MAX_KERNELS];
   logic [6:0]         cfg_active;
   logic [15:0]        cfg_inv_sigma;
   logic [16:0]        gauss_lut [EXP_DEPTH];

   // Generator bookkeeping, so no evaluate ever touches an unwritten entry.
   int gen_count = MAX_KERNELS;
   bit has_center [MAX_KERNELS];
   bit has_weight [NUM_OUTPUTS][MAX_KERNELS];
   int gen_cx [MAX_KERNELS];
   int gen_cy [MAX_KERNELS];
   int gen_items = 0;
   int gen_evals = 0;

   int error_count = 0;
   int requests_taken = 0;
   int evals_taken = 0;
   int csr_writes = 0;
   int results_checked = 0;
   int idle_cycles = 0;

   int burst_left;
   int gap_left;
   int settle_wait;
   logic [15:0] stall_pattern;
   int pattern_age;

   task automatic report_mismatch(input string msg);
      $display("ERROR: %s", msg);
      error_count++;
   endtask

   task automatic push_op(input op_type op, input int kidx, input int sel,
                          input int a, input int b);
      backlog_type e;
      e.is_csr             = 1'b0;
      e.req.operation      = op;
      e.req.kernel_index   = kidx[5:0];
      e.req.output_select  = sel[1:0];
      e.req.value_a        = a[15:0];
      e.req.value_b        = b[15:0];
      e.reg_index          = '0;
      e.wdata              = '0;
      op_backlog.insert(op_backlog.size(), e);
      if (op == OP_WRITE_CENTER) begin
         has_center[kidx[5:0]] = 1'b1;
         gen_cx[kidx[5:0]]     = a;
         gen_cy[kidx[5:0]]     = b;
      end else if (op == OP_WRITE_WEIGHT) begin
         has_weight[sel[1:0]][kidx[5:0]] = 1'b1;
      end
      if (op != OP_RESERVED) begin
         gen_items++;
      end
      if (op == OP_EVALUATE) begin
         gen_evals++;
      end
   endtask

   task automatic push_csr(input logic [7:0] idx, input int data);
      backlog_type e;
      e.is_csr    = 1'b1;
      e.req       = '0;
      e.reg_index = idx;
      e.wdata     = data[15:0];
      op_backlog.insert(op_backlog.size(), e);
      if (idx == CSR_ACTIVE_KERNELS) begin
         gen_count = (data[6:0] > MAX_KERNELS) ? MAX_KERNELS : int'(data[6:0]);
      end
   endtask

   // Mostly modest weights, sometimes full range to push the sums into saturation.
   function automatic int pick_weight();
      return ($urandom_range(0, 9) < 3) ? $urandom_range(0, 65535)
                                        : $urandom_range(0, 4095) - 2048;
   endfunction

   // Evaluate at (a, b), first loading any center or weight it would read.
   task automatic push_eval(input int a, input int b);
      for (int k = 0; k < gen_count; k++) begin
         if (!has_center[k]) begin
            push_op(OP_WRITE_CENTER, k, $urandom_range(0, 3),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
         end
         for (int s = 0; s < NUM_OUTPUTS; s++) begin
            if (!has_weight[s][k]) begin
               push_op(OP_WRITE_WEIGHT, k, s, pick_weight(), $urandom_range(0, 65535));
            end
         end
      end
      push_op(OP_EVALUATE, $urandom_range(0, 63), $urandom_range(0, 3), a, b);
   endtask

   // exp(-16*i/depth) in Q1.16: series through the 14th power on a sixteenth of the argument,
   // then squared four times, all in Q30.
   initial begin : build_lut
      logic [63:0] frac;
      logic [63:0] term;
      logic [63:0] series;
      for (int i = 0; i < EXP_DEPTH; i++) begin
         frac   = (64'(i) << 30) / EXP_DEPTH;
         term   = Q30_ONE;
         series = Q30_ONE;
         for (int k = 1; k <= 14; k++) begin
            term = ((term * frac) >> 30) / 64'(k);
            if ((k % 2) == 1) begin
               series = (series >= term) ? series - term : 64'd0;
            end else begin
               series = series + term;
            end
         end
         if (series > Q30_ONE) begin
            series = Q30_ONE;
         end
         repeat (4) series = (series * series + (Q30_ONE >> 1)) >> 30;
         series = (series + 64'd8192) >> 14;
         gauss_lut[i] = (series > 64'd65536) ? 17'd65536 : series[16:0];
      end
   end

   // Sender: bursts and gaps; holds register writes until the network is idle.
   always @(posedge clock) begin : drive
      logic               nxt_valid;
      grbf_req_type       nxt_req;
      logic               nxt_csr;
      logic [7:0]         nxt_index;
      logic [15:0]        nxt_wdata;
      backlog_type        head;
      longint             acc [NUM_OUTPUTS];
      longint             dx;
      longint             dy;
      longint             d2;
      longint             lut_idx;
      longint             act;
      longint             rounded;
      int                 n;
      logic signed [15:0] ang [4];
      grbf_rsp_type       outcome;
      if (reset) begin
         req_valid     <= 1'b0;
         csr_valid     <= 1'b0;
         cfg_active    = 7'd64;
         cfg_inv_sigma = 16'd256;
         burst_left    = 0;
         gap_left      = 0;
         settle_wait   = 0;
      end else begin
         nxt_valid = req_valid;
         nxt_req   = req_data;
         nxt_csr   = csr_valid;
         nxt_index = csr_index;
         nxt_wdata = csr_wdata;

         if (req_valid && req_ready) begin
            requests_taken++;
            nxt_valid = 1'b0;
            case (req_data.operation)
               OP_WRITE_CENTER: begin
                  center_x[req_data.kernel_index] = req_data.value_a;
                  center_y[req_data.kernel_index] = req_data.value_b;
               end
               OP_WRITE_WEIGHT: begin
                  weight_mem[req_data.output_select][req_data.kernel_index] = req_data.value_a;
               end
               OP_EVALUATE: begin
                  evals_taken++;
                  n = (cfg_active > MAX_KERNELS) ? MAX_KERNELS : int'(cfg_active);
                  for (int j = 0; j < NUM_OUTPUTS; j++) acc[j] = 0;
                  for (int k = 0; k < n; k++) begin
                     dx = longint'($signed(req_data.value_a)) - longint'($signed(center_x[k]));
                     dy = longint'($signed(req_data.value_b)) - longint'($signed(center_y[k]));
                     d2 = dx * dx + dy * dy;
                     // Q6.28 distance times Q8.8 width, scaled to table entries
                     lut_idx = (d2 * longint'(cfg_inv_sigma) * EXP_DEPTH) >>> 40;
                     act = (lut_idx < EXP_DEPTH) ? longint'(gauss_lut[lut_idx]) : 0;
                     for (int j = 0; j < NUM_OUTPUTS; j++) begin
                        acc[j] += longint'($signed(weight_mem[j][k])) * act;
                     end
                  end
                  for (int j = 0; j < 4; j++) begin
                     rounded = (acc[j] + 32768) >>> 16;   // round half up
                     if (rounded > 32767) rounded = 32767;
                     if (rounded < -32768) rounded = -32768;
                     ang[j] = rounded[15:0];
                  end
                  outcome = '{ang[0], ang[1], ang[2], ang[3]};
                  angle_queue.insert(angle_queue.size(), outcome);
               end
               default: ;   // reserved operation: no effect
            endcase
         end

         if (csr_valid && csr_ready) begin
            csr_writes++;
            nxt_csr = 1'b0;
            if (csr_index == CSR_ACTIVE_KERNELS) begin
               cfg_active = csr_wdata[6:0];
            end else if (csr_index == CSR_INV_SIGMA) begin
               cfg_inv_sigma = csr_wdata;
            end
         end

         if (!nxt_valid && !nxt_csr && op_backlog.size() != 0) begin
            if (op_backlog[0].is_csr) begin
               // drain all results, then let any trailing load settle
               if (angle_queue.size() != 0) begin
                  settle_wait = 0;
               end else if (settle_wait < SETTLE_CYCLES) begin
                  settle_wait++;
               end else begin
                  head        = op_backlog.pop_front();
                  nxt_csr     = 1'b1;
                  nxt_index   = head.reg_index;
                  nxt_wdata   = head.wdata;
                  settle_wait = 0;
               end
            end else if (gap_left != 0) begin
               gap_left--;
            end else begin
               head      = op_backlog.pop_front();
               nxt_valid = 1'b1;
               nxt_req   = head.req;
               if (burst_left != 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
                  gap_left   = $urandom_range(1, 10);
               end
            end
         end

         req_valid <= nxt_valid;
         req_data  <= nxt_req;
         csr_valid <= nxt_csr;
         csr_index <= nxt_index;
         csr_wdata <= nxt_wdata;
      end
   end

   // Receiver: checks each result, stalls on a rotating pattern.
   always @(posedge clock) begin : observe
      grbf_rsp_type want;
      if (reset) begin
         rsp_ready     <= 1'b0;
         idle_cycles   = 0;
         stall_pattern = 16'hFFFF;
         pattern_age   = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (angle_queue.size() == 0) begin
               report_mismatch($sformatf("result %h with no evaluate pending", rsp_data));
            end else begin
               want = angle_queue.pop_front();
               if (rsp_data.angle_0 !== want.angle_0)
                  report_mismatch($sformatf("result %0d angle_0 %0d, want %0d",
                                  results_checked, rsp_data.angle_0, want.angle_0));
               if (rsp_data.angle_1 !== want.angle_1)
                  report_mismatch($sformatf("result %0d angle_1 %0d, want %0d",
                                  results_checked, rsp_data.angle_1, want.angle_1));
               if (rsp_data.angle_2 !== want.angle_2)
                  report_mismatch($sformatf("result %0d angle_2 %0d, want %0d",
                                  results_checked, rsp_data.angle_2, want.angle_2));
               if (rsp_data.angle_3 !== want.angle_3)
                  report_mismatch($sformatf("result %0d angle_3 %0d, want %0d",
                                  results_checked, rsp_data.angle_3, want.angle_3));
            end
         end

         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;

         pattern_age++;
         if (pattern_age == 256) begin
            pattern_age   = 0;
            stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                        : (16'($urandom) | 16'h0001);
         end else begin
            stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
         end
         rsp_ready <= stall_pattern[0];
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin : run
      int active_pick;
      int inv_pick;
      int pick;
      int k;
      int random_goal;
      int eval_goal;

      // Directed: one kernel first, so results are easy to reason about.
      push_csr(CSR_ACTIVE_KERNELS, 1);
      push_op(OP_WRITE_CENTER, 0, 0, 0, 0);
      push_op(OP_WRITE_WEIGHT, 0, 0, 32767, 0);
      push_op(OP_WRITE_WEIGHT, 0, 1, -32768, 0);
      push_op(OP_WRITE_WEIGHT, 0, 2, 4096, 0);
      push_op(OP_WRITE_WEIGHT, 0, 3, -1, 0);
      push_eval(0, 0);                 // on center: full activation, outputs equal the weights
      push_eval(16384, 0);             // unit distance
      push_eval(32767, -32768);
      push_eval(-32768, 32767);
      push_op(OP_RESERVED, 63, 3, -1, -1);
      push_op(OP_WRITE_CENTER, 63, 3, 32767, 32767);
      push_op(OP_WRITE_WEIGHT, 63, 3, 32767, -32768);
      push_op(OP_WRITE_CENTER, 0, 0, -32768, -32768);
      push_eval(32767, 32767);         // largest distance, past the table end
      push_csr(CSR_INV_SIGMA, 0);      // every distance maps to table entry zero
      push_eval(32767, 32767);
      push_csr(CSR_INV_SIGMA, 65535);  // narrowest width
      push_eval(-32768, -32760);
      push_csr(CSR_ACTIVE_KERNELS, 0); // no kernels: all outputs zero
      push_eval(12345, -12345);
      push_csr(CSR_UNMAPPED_LO, 16'hFFFF);
      push_csr(CSR_UNMAPPED_HI, 16'h0000);
      push_eval(0, 0);
      push_csr(CSR_ACTIVE_KERNELS, 127); // clamps to the full table
      push_csr(CSR_INV_SIGMA, 256);
      push_eval(0, 0);

      // Random phases, each with its own register setting; the directed part
      // already loads the full table, so about 500 requests in all.
      random_goal = gen_items + 150;
      eval_goal   = gen_evals + 70;
      while (gen_items < random_goal || gen_evals < eval_goal) begin
         case ($urandom_range(0, 5))
            0:       active_pick = $urandom_range(0, 2);
            1, 2:    active_pick = $urandom_range(1, 16);
            3:       active_pick = $urandom_range(17, 63);
            4:       active_pick = MAX_KERNELS;
            default: active_pick = $urandom_range(65, 127);
         endcase
         case ($urandom_range(0, 5))
            0:       inv_pick = 0;
            1:       inv_pick = 65535;
            2:       inv_pick = 256;
            3:       inv_pick = $urandom_range(1, 255);
            4:       inv_pick = $urandom_range(257, 4095);
            default: inv_pick = $urandom_range(0, 65535);
         endcase
         push_csr(CSR_ACTIVE_KERNELS, active_pick);
         push_csr(CSR_INV_SIGMA, inv_pick);
         repeat ($urandom_range(20, 60)) begin
            pick = $urandom_range(0, 99);
            if (pick < 35 && gen_count > 0) begin
               // near a live center so narrow widths still give activations
               k = $urandom_range(0, gen_count - 1);
               push_eval(gen_cx[k] + $urandom_range(0, 511) - 256,
                         gen_cy[k] + $urandom_range(0, 511) - 256);
            end else if (pick < 50) begin
               push_eval($urandom_range(0, 65535), $urandom_range(0, 65535));
            end else if (pick < 72) begin
               push_op(OP_WRITE_CENTER, $urandom_range(0, 63), $urandom_range(0, 3),
                       $urandom_range(0, 65535), $urandom_range(0, 65535));
            end else if (pick < 95) begin
               push_op(OP_WRITE_WEIGHT, $urandom_range(0, 63), $urandom_range(0, 3),
                       pick_weight(), $urandom_range(0, 65535));
            end else begin
               push_op(OP_RESERVED, $urandom_range(0, 63), $urandom_range(0, 3),
                       $urandom_range(0, 65535), $urandom_range(0, 65535));
            end
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (op_backlog.size() != 0 || req_valid || csr_valid || angle_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (angle_queue.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", angle_queue.size()));

      $display("Ran %0d requests (%0d evaluates, %0d results checked) over %0d register writes",
               requests_taken, evals_taken, results_checked, csr_writes);
      $display("Mismatches: %0d", error_count);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
